/* hw/rtl/cdrs_pkg.sv */
// cdrs_pkg: shared types and constants for the CD ring stream controller.
// Used by cdrs_msf, cdrs_ctrl and cdrom_ring_stream_controller; no dependencies.
`default_nettype none

package cdrs_pkg;

    // Ring and run geometry
    localparam int unsigned RING_BYTES   = 32768;
    localparam int unsigned RUN_SECTORS  = 8;
    localparam int unsigned SECTOR_BYTES = 2048;
    localparam int          SECT_SHIFT   = $clog2(SECTOR_BYTES);
    localparam logic [14:0] RING_ADDR_MASK = 15'(RING_BYTES - 1);

    // Sector counter holds up to 2^21 sectors plus headroom
    localparam int SI_W    = 22;
    localparam int RUN_W   = $clog2(RUN_SECTORS + 1);
    localparam int FRAME_W = 22;

    // MSF conversion
    localparam int unsigned PREGAP_FRAMES   = 150;
    localparam int unsigned FRAMES_PER_SEC  = 75;
    localparam int unsigned SECS_PER_MIN    = 60;
    localparam int unsigned FRAMES_PER_MIN  = FRAMES_PER_SEC * SECS_PER_MIN;
    localparam int          MIN_SHIFT       = 24;
    localparam int unsigned MIN_RECIP       = (1 << MIN_SHIFT) / FRAMES_PER_MIN;
    localparam int          SEC_SHIFT       = 14;
    localparam int unsigned SEC_RECIP       = (1 << SEC_SHIFT) / FRAMES_PER_SEC;

    // Configuration register indexes
    localparam logic [1:0] CFG_START_SECTOR = 2'd0;
    localparam logic [1:0] CFG_FILE_BYTES   = 2'd1;
    localparam logic [1:0] CFG_LOOP_ENABLE  = 2'd2;

    typedef struct packed {
        logic        step_enable;
        logic [31:0] read_pos;
        logic        drive_ready;
        logic        status_waiting;
        logic [7:0]  status_code;
        logic [7:0]  data_byte;
    } in_t;

    typedef struct packed {
        logic        port_write;
        logic [1:0]  port_select;
        logic [7:0]  port_value;
        logic [1:0]  port_read;
        logic        ring_write;
        logic [14:0] ring_addr;
        logic [7:0]  ring_data;
        logic [31:0] fill_count;
        logic [2:0]  stream_state;
    } out_t;

    typedef struct packed {
        logic [18:0]     start_sector;
        logic [31:0]     file_bytes;
        logic            loop_enable;
        logic [SI_W-1:0] sector_total;
    } cfg_t;

    // One BCD minute-second-frame triple plus conversion-in-flight flag
    typedef struct packed {
        logic       busy;
        logic [7:0] mm;
        logic [7:0] ss;
        logic [7:0] ff;
    } msf_t;

    // ((v/10)<<4 | v%10) truncated to a byte; v*205>>11 is exact below 1029
    function automatic logic [7:0] to_bcd(input logic [9:0] v);
        logic [17:0] prod;
        logic [6:0]  tens;
        logic [9:0]  tens_x10;
        logic [9:0]  ones;
        prod     = 18'(v) * 18'd205;
        tens     = prod[17:11];
        tens_x10 = (10'(tens) << 3) + (10'(tens) << 1);
        ones     = v - tens_x10;
        return {tens[3:0], ones[3:0]};
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/cdrs_msf.sv */
// cdrs_msf: pipelined LBA to BCD minute-second-frame converter (8 stages).
// Depends on cdrs_pkg for widths, reciprocal constants and to_bcd.
`default_nettype none

module cdrs_msf (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          launch,
    input  wire logic [cdrs_pkg::FRAME_W-1:0]  lba,
    input  wire logic [cdrs_pkg::RUN_W-1:0]    offset,
    output cdrs_pkg::msf_t                     result
);

    localparam int FW      = cdrs_pkg::FRAME_W;
    localparam int MIN_W   = 10;
    localparam int REM2_W  = 14;
    localparam int REM_W   = 13;
    localparam int PROD1_W = FW + 12;
    localparam int PROD4_W = REM_W + 8;

    logic [6:0]         vld_reg, vld_next;
    logic [FW-1:0]      frm0_reg, frm0_next;
    logic [PROD1_W-1:0] prod1_reg, prod1_next;
    logic [FW-1:0]      frm1_reg, frm1_next;
    logic [MIN_W-1:0]   min2_reg, min2_next;
    logic [REM2_W-1:0]  rem2_reg, rem2_next;
    logic [MIN_W-1:0]   min3_reg, min3_next;
    logic [REM_W-1:0]   rem3_reg, rem3_next;
    logic [PROD4_W-1:0] prod4_reg, prod4_next;
    logic [REM_W-1:0]   rem4_reg, rem4_next;
    logic [MIN_W-1:0]   min4_reg, min4_next;
    logic [6:0]         sec5_reg, sec5_next;
    logic [7:0]         frm5_reg, frm5_next;
    logic [MIN_W-1:0]   min5_reg, min5_next;
    logic [6:0]         sec6_reg, sec6_next;
    logic [7:0]         frm6_reg, frm6_next;
    logic [MIN_W-1:0]   min6_reg, min6_next;
    logic [7:0]         mm_reg, mm_next;
    logic [7:0]         ss_reg, ss_next;
    logic [7:0]         ff_reg, ff_next;
    logic [FW-1:0]      min_frames;
    logic [REM_W-1:0]   sec_frames;

    always_comb
    begin
        vld_next = {vld_reg[5:0], launch};

        // stage 0: absolute frame number
        frm0_next = lba + FW'(offset) + FW'(cdrs_pkg::PREGAP_FRAMES);

        // stage 1: minutes estimate by reciprocal
        prod1_next = PROD1_W'(frm0_reg) * PROD1_W'(cdrs_pkg::MIN_RECIP);
        frm1_next  = frm0_reg;

        // stage 2: remainder, may still hold one extra minute
        min2_next  = MIN_W'(prod1_reg >> cdrs_pkg::MIN_SHIFT);
        min_frames = FW'(min2_next) * FW'(cdrs_pkg::FRAMES_PER_MIN);
        rem2_next  = REM2_W'(frm1_reg - min_frames);

        // stage 3: correction
        if (rem2_reg >= REM2_W'(cdrs_pkg::FRAMES_PER_MIN))
        begin
            min3_next = min2_reg + MIN_W'(1);
            rem3_next = REM_W'(rem2_reg - REM2_W'(cdrs_pkg::FRAMES_PER_MIN));
        end
        else
        begin
            min3_next = min2_reg;
            rem3_next = REM_W'(rem2_reg);
        end

        // stage 4: seconds estimate
        prod4_next = PROD4_W'(rem3_reg) * PROD4_W'(cdrs_pkg::SEC_RECIP);
        rem4_next  = rem3_reg;
        min4_next  = min3_reg;

        // stage 5: frame remainder
        sec5_next  = 7'(prod4_reg >> cdrs_pkg::SEC_SHIFT);
        sec_frames = REM_W'(sec5_next) * REM_W'(cdrs_pkg::FRAMES_PER_SEC);
        frm5_next  = 8'(rem4_reg - sec_frames);
        min5_next  = min4_reg;

        // stage 6: correction
        if (frm5_reg >= 8'(cdrs_pkg::FRAMES_PER_SEC))
        begin
            sec6_next = sec5_reg + 7'd1;
            frm6_next = frm5_reg - 8'(cdrs_pkg::FRAMES_PER_SEC);
        end
        else
        begin
            sec6_next = sec5_reg;
            frm6_next = frm5_reg;
        end
        min6_next = min5_reg;

        // stage 7: BCD, held until the next conversion
        if (vld_reg[6])
        begin
            mm_next = cdrs_pkg::to_bcd(min6_reg);
            ss_next = cdrs_pkg::to_bcd(10'(sec6_reg));
            ff_next = cdrs_pkg::to_bcd(10'(frm6_reg));
        end
        else
        begin
            mm_next = mm_reg;
            ss_next = ss_reg;
            ff_next = ff_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        frm0_reg  <= frm0_next;
        prod1_reg <= prod1_next;
        frm1_reg  <= frm1_next;
        min2_reg  <= min2_next;
        rem2_reg  <= rem2_next;
        min3_reg  <= min3_next;
        rem3_reg  <= rem3_next;
        prod4_reg <= prod4_next;
        rem4_reg  <= rem4_next;
        min4_reg  <= min4_next;
        sec5_reg  <= sec5_next;
        frm5_reg  <= frm5_next;
        min5_reg  <= min5_next;
        sec6_reg  <= sec6_next;
        frm6_reg  <= frm6_next;
        min6_reg  <= min6_next;
        mm_reg    <= mm_next;
        ss_reg    <= ss_next;
        ff_reg    <= ff_next;
    end

    assign result.busy = |vld_reg;
    assign result.mm   = mm_reg;
    assign result.ss   = ss_reg;
    assign result.ff   = ff_reg;

endmodule

`default_nettype wire

/* hw/rtl/cdrs_ctrl.sv */
// cdrs_ctrl: streaming state machine, fill/sector counters and command sequencing.
// Depends on cdrs_pkg and cdrs_msf (two instances: run start and run end).
`default_nettype none

module cdrs_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           fire,
    input  wire cdrs_pkg::in_t  item,
    input  wire cdrs_pkg::cfg_t cfg,
    output cdrs_pkg::out_t      res
);

    typedef enum logic [7:0] {
        PH_IDLE       = 8'b0000_0001,
        PH_SETUP      = 8'b0000_0010,
        PH_SETUP_WAIT = 8'b0000_0100,
        PH_ISSUE      = 8'b0000_1000,
        PH_WAIT       = 8'b0001_0000,
        PH_XFER       = 8'b0010_0000,
        PH_DONE       = 8'b0100_0000,
        PH_ERROR      = 8'b1000_0000
    } phase_t;

    localparam logic [2:0] ST_IDLE       = 3'd0;
    localparam logic [2:0] ST_SETUP      = 3'd1;
    localparam logic [2:0] ST_SETUP_WAIT = 3'd2;
    localparam logic [2:0] ST_ISSUE      = 3'd3;
    localparam logic [2:0] ST_WAIT       = 3'd4;
    localparam logic [2:0] ST_XFER       = 3'd5;
    localparam logic [2:0] ST_DONE       = 3'd6;
    localparam logic [2:0] ST_ERROR      = 3'd7;

    localparam logic [1:0] PSEL_PARAM  = 2'd0;
    localparam logic [1:0] PSEL_CMD    = 2'd1;
    localparam logic [1:0] PSEL_XFER   = 2'd2;
    localparam logic [1:0] PSEL_MASTER = 2'd3;

    localparam logic [1:0] RD_NONE   = 2'd0;
    localparam logic [1:0] RD_STATUS = 2'd1;
    localparam logic [1:0] RD_DATA   = 2'd2;

    localparam logic [7:0] CMD_SETUP      = 8'hA0;
    localparam logic [7:0] SETUP_MODE     = 8'h08;
    localparam logic [7:0] SETUP_ARG      = 8'h01;
    localparam logic [7:0] CMD_READ       = 8'h02 | 8'h20;
    localparam logic [7:0] XFER_ENABLE    = 8'h08;
    localparam logic [7:0] SECTOR_ACK     = 8'hC0;
    localparam logic [7:0] STAT_NONE      = 8'h00;
    localparam logic [7:0] STAT_READ_DONE = 8'h06;
    localparam logic [7:0] STAT_DATA_END  = 8'h21;
    localparam logic [7:0] STAT_DATA_RDY  = 8'h22;

    localparam logic [3:0] CMD_LAST = 4'd8;
    localparam logic [3:0] CMD_NONE = 4'd9;

    localparam int SI_W = cdrs_pkg::SI_W;
    localparam int BI_W = cdrs_pkg::SECT_SHIFT;
    localparam int RW   = cdrs_pkg::RUN_W;

    phase_t          phase_reg, phase_next;
    logic [31:0]     fill_reg, fill_next;
    logic [SI_W-1:0] si_reg, si_next;
    logic [BI_W-1:0] byte_reg, byte_next;
    logic [3:0]      cmd_reg, cmd_next;

    logic [31:0]     pending;
    logic [31:0]     free_bytes;
    logic [SI_W-1:0] si_eff;
    logic [SI_W-1:0] remaining;
    logic [RW-1:0]   run;
    logic [31:0]     need;
    logic [SI_W+BI_W-1:0] xfer_pos;
    logic [7:0]      issue_byte;
    logic [7:0]      setup_byte;
    logic            launch;
    logic            in_setup;
    cdrs_pkg::msf_t  msf_lo;
    cdrs_pkg::msf_t  msf_hi;

    // run start and inclusive run end
    cdrs_msf u_msf_lo (
        .clk    (clk),
        .rst_n  (rst_n),
        .launch (launch),
        .lba    (cdrs_pkg::FRAME_W'(cfg.start_sector) + cdrs_pkg::FRAME_W'(si_eff)),
        .offset ('0),
        .result (msf_lo)
    );

    cdrs_msf u_msf_hi (
        .clk    (clk),
        .rst_n  (rst_n),
        .launch (launch),
        .lba    (cdrs_pkg::FRAME_W'(cfg.start_sector) + cdrs_pkg::FRAME_W'(si_eff)),
        .offset (run - RW'(1)),
        .result (msf_hi)
    );

    always_comb
    begin
        pending    = fill_reg - item.read_pos;
        free_bytes = 32'(cdrs_pkg::RING_BYTES) - pending;

        if (si_reg >= cfg.sector_total)
            si_eff = '0;
        else
            si_eff = si_reg;

        remaining = cfg.sector_total - si_eff;
        if (remaining > SI_W'(cdrs_pkg::RUN_SECTORS))
            run = RW'(cdrs_pkg::RUN_SECTORS);
        else
            run = RW'(remaining);
        need = 32'(run) << cdrs_pkg::SECT_SHIFT;

        xfer_pos = {si_reg, byte_reg};
        in_setup = (phase_reg == PH_SETUP);

        case (cmd_reg)
            4'd0:    issue_byte = msf_lo.mm;
            4'd1:    issue_byte = msf_lo.ss;
            4'd2:    issue_byte = msf_lo.ff;
            4'd3:    issue_byte = msf_hi.mm;
            4'd4:    issue_byte = msf_hi.ss;
            4'd5:    issue_byte = msf_hi.ff;
            default: issue_byte = 8'h00;
        endcase

        case (cmd_reg)
            4'd0:    setup_byte = SETUP_MODE;
            4'd1:    setup_byte = SETUP_ARG;
            default: setup_byte = 8'h00;
        endcase

        phase_next = phase_reg;
        fill_next  = fill_reg;
        si_next    = si_reg;
        byte_next  = byte_reg;
        cmd_next   = cmd_reg;
        launch     = 1'b0;

        res             = '0;
        res.port_read   = RD_NONE;

        if (fire && item.step_enable)
        begin
            case (phase_reg)
                PH_IDLE:
                begin
                    if (cfg.sector_total == '0)
                        phase_next = PH_DONE;
                    else if (si_reg >= cfg.sector_total && !cfg.loop_enable)
                        phase_next = PH_DONE;
                    else
                    begin
                        si_next = si_eff;
                        if (free_bytes >= need)
                        begin
                            launch     = 1'b1;
                            cmd_next   = '0;
                            phase_next = PH_SETUP;
                        end
                    end
                end
                PH_SETUP, PH_ISSUE:
                begin
                    if (item.drive_ready && cmd_reg < CMD_NONE)
                    begin
                        res.port_write = 1'b1;
                        if (cmd_reg < CMD_LAST)
                        begin
                            res.port_select = PSEL_PARAM;
                            res.port_value  = in_setup ? setup_byte : issue_byte;
                        end
                        else
                        begin
                            res.port_select = PSEL_CMD;
                            res.port_value  = in_setup ? CMD_SETUP : CMD_READ;
                        end
                        cmd_next = cmd_reg + 4'd1;
                        if (cmd_reg == CMD_LAST)
                            phase_next = in_setup ? PH_SETUP_WAIT : PH_WAIT;
                    end
                end
                PH_SETUP_WAIT:
                begin
                    if (item.status_waiting)
                    begin
                        res.port_read = RD_STATUS;
                        cmd_next      = '0;
                        phase_next    = PH_ISSUE;
                    end
                end
                PH_WAIT:
                begin
                    if (item.status_waiting)
                    begin
                        res.port_read = RD_STATUS;
                        if (item.status_code inside {STAT_DATA_RDY, STAT_DATA_END})
                        begin
                            res.port_write  = 1'b1;
                            res.port_select = PSEL_XFER;
                            res.port_value  = XFER_ENABLE;
                            byte_next       = '0;
                            phase_next      = PH_XFER;
                        end
                        else if (item.status_code == STAT_READ_DONE)
                        begin
                            res.port_write  = 1'b1;
                            res.port_select = PSEL_MASTER;
                            res.port_value  = SECTOR_ACK;
                            phase_next      = PH_IDLE;
                        end
                        else if (item.status_code != STAT_NONE)
                            phase_next = PH_ERROR;
                    end
                end
                PH_XFER:
                begin
                    res.port_read = RD_DATA;
                    // padding past file end is drained but not stored
                    if ({1'b0, xfer_pos} < (SI_W+BI_W+1)'(cfg.file_bytes))
                    begin
                        res.ring_write = 1'b1;
                        res.ring_addr  = fill_reg[14:0] & cdrs_pkg::RING_ADDR_MASK;
                        res.ring_data  = item.data_byte;
                        fill_next      = fill_reg + 32'd1;
                    end
                    byte_next = byte_reg + BI_W'(1);
                    if (&byte_reg)
                    begin
                        res.port_write  = 1'b1;
                        res.port_select = PSEL_MASTER;
                        res.port_value  = SECTOR_ACK;
                        si_next         = (&si_reg) ? si_reg : si_reg + SI_W'(1);
                        phase_next      = PH_WAIT;
                    end
                end
                default:
                begin
                end
            endcase
        end

        res.fill_count = fill_next;
        case (phase_next)
            PH_IDLE:       res.stream_state = ST_IDLE;
            PH_SETUP:      res.stream_state = ST_SETUP;
            PH_SETUP_WAIT: res.stream_state = ST_SETUP_WAIT;
            PH_ISSUE:      res.stream_state = ST_ISSUE;
            PH_WAIT:       res.stream_state = ST_WAIT;
            PH_XFER:       res.stream_state = ST_XFER;
            PH_DONE:       res.stream_state = ST_DONE;
            PH_ERROR:      res.stream_state = ST_ERROR;
            default:       res.stream_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            fill_reg  <= '0;
            si_reg    <= '0;
            byte_reg  <= '0;
            cmd_reg   <= CMD_NONE;
        end
        else if (fire)
        begin
            phase_reg <= phase_next;
            fill_reg  <= fill_next;
            si_reg    <= si_next;
            byte_reg  <= byte_next;
            cmd_reg   <= cmd_next;
        end
    end

    // MSF bytes must be settled before the read command goes out
    a_msf_settled: assert property (@(posedge clk) disable iff (!rst_n)
        fire && phase_reg == PH_ISSUE |-> !msf_lo.busy && !msf_hi.busy)
        else $error("read command issued while MSF conversion in flight");

    a_ring_needs_data: assert property (@(posedge clk) disable iff (!rst_n)
        res.ring_write |-> res.port_read == RD_DATA)
        else $error("ring write without a data port read");

    a_fill_only_on_store: assert property (@(posedge clk) disable iff (!rst_n)
        fire && !res.ring_write |=> $stable(fill_reg))
        else $error("fill position moved without a ring write");

    a_hold_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> $stable(phase_reg) && $stable(si_reg) && $stable(cmd_reg))
        else $error("state changed without an advancing request");

endmodule

`default_nettype wire

/* hw/rtl/cdrom_ring_stream_controller.sv */
// A request accepted into the input register steps cdrs_ctrl, and its result is captured in the
// result register and shown on out_valid; out_stall can hold it there. One request per clock is
// taken while out_stall does not hold a full result register; the MSF converter runs alongside.
// Reset (rst_n low, async): state idle, fill/sector counters zero, config registers zero, pipe empty.
// Depends on cdrs_pkg, cdrs_ctrl, cdrs_msf.
`default_nettype none

module cdrom_ring_stream_controller (
    input  wire logic          clk,
    input  wire logic          rst_n,
    // request side
    input  wire logic          in_valid,
    output logic               in_stall,
    input  wire cdrs_pkg::in_t in_item,
    // result side
    output logic               out_valid,
    input  wire logic          out_stall,
    output cdrs_pkg::out_t     out_item,
    // configuration writes
    input  wire logic          cfg_write,
    input  wire logic [1:0]    cfg_index,
    input  wire logic [31:0]   cfg_data
);

    // Input register: holds one request until the result register can take its result.
    logic           in_full_reg, in_full_next;
    cdrs_pkg::in_t  in_item_reg, in_item_next;
    // Result register: parts the two sides, so a new request is taken while a result waits.
    logic           out_full_reg, out_full_next;
    cdrs_pkg::out_t out_item_reg, out_item_next;

    // Configuration registers; total sector count is precomputed on file size write.
    logic [18:0]             start_reg, start_next;
    logic [31:0]             file_reg, file_next;
    logic                    loop_reg, loop_next;
    logic [cdrs_pkg::SI_W-1:0] total_reg, total_next;

    logic           out_free;
    logic           advance;
    logic           in_take;
    cdrs_pkg::cfg_t cfg;
    cdrs_pkg::out_t step_res;

    assign out_free = !out_full_reg || !out_stall;
    assign advance  = in_full_reg && out_free;
    assign in_stall = in_full_reg && !out_free;
    assign in_take  = in_valid && !in_stall;

    assign cfg.start_sector  = start_reg;
    assign cfg.file_bytes    = file_reg;
    assign cfg.loop_enable   = loop_reg;
    assign cfg.sector_total  = total_reg;

    cdrs_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (advance),
        .item  (in_item_reg),
        .cfg   (cfg),
        .res   (step_res)
    );

    always_comb
    begin
        // input stage
        if (in_take)
            in_full_next = 1'b1;
        else if (advance)
            in_full_next = 1'b0;
        else
            in_full_next = in_full_reg;
        in_item_next = in_take ? in_item : in_item_reg;

        // result stage
        out_full_next = out_free ? advance : out_full_reg;
        out_item_next = advance ? step_res : out_item_reg;

        // config writes; index 3 is ignored
        start_next = start_reg;
        file_next  = file_reg;
        loop_next  = loop_reg;
        total_next = total_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                cdrs_pkg::CFG_START_SECTOR: start_next = cfg_data[18:0];
                cdrs_pkg::CFG_FILE_BYTES:
                begin
                    file_next  = cfg_data;
                    // ceil(bytes / sector size), no wrap
                    total_next = cdrs_pkg::SI_W'(cfg_data >> cdrs_pkg::SECT_SHIFT)
                               + cdrs_pkg::SI_W'(|cfg_data[cdrs_pkg::SECT_SHIFT-1:0]);
                end
                cdrs_pkg::CFG_LOOP_ENABLE:  loop_next = cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg  <= 1'b0;
            out_full_reg <= 1'b0;
            start_reg    <= '0;
            file_reg     <= '0;
            loop_reg     <= 1'b0;
            total_reg    <= '0;
        end
        else
        begin
            in_full_reg  <= in_full_next;
            out_full_reg <= out_full_next;
            start_reg    <= start_next;
            file_reg     <= file_next;
            loop_reg     <= loop_next;
            total_reg    <= total_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_item_reg  <= in_item_next;
        out_item_reg <= out_item_next;
    end

    assign out_valid = out_full_reg;
    assign out_item  = out_item_reg;

endmodule

`default_nettype wire
